// ===== rtl/pvfm_pkg.sv =====
// shared types, constants and lookup tables of the voxel face mesher
`timescale 1ns / 1ps
package pvfm_pkg;

   localparam int NumBlockTypes = 256;
   localparam int NumSlots = 6;
   localparam int TableDepth = NumBlockTypes * NumSlots;
   localparam int TableAw = $clog2(TableDepth);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [2:0] face;
      logic [19:0] ao_corners;
      logic [4:0] pos_x;
      logic [4:0] pos_y;
      logic [4:0] pos_z;
      logic [2:0] direction;
      logic [1:0] rotation;
      logic [7:0] block_type;
      logic [3:0] damage;
      logic [7:0] tile_value;
   } req_type;

   typedef struct packed {
      logic [31:0] vertex_word0;
      logic [9:0]  vertex_word1;
      logic        last_vertex;
   } rsp_type;

   // cube corner of each face corner
   function automatic logic [2:0] corner_of(input logic [2:0] f, input logic [1:0] j);
      logic [11:0] row;
      case (f)
         3'd0: row = {3'd5, 3'd2, 3'd1, 3'd0};
         3'd1: row = {3'd7, 3'd4, 3'd6, 3'd3};
         3'd2: row = {3'd7, 3'd4, 3'd5, 3'd2};
         3'd3: row = {3'd6, 3'd3, 3'd1, 3'd0};
         3'd4: row = {3'd4, 3'd3, 3'd2, 3'd0};
         default: row = {3'd7, 3'd6, 3'd5, 3'd1};
      endcase
      return row[3*j +: 3];
   endfunction

   // texture slot per direction, rotation, face (packed face 0 at low bits)
   function automatic logic [2:0] slot_of(input logic [2:0] d, input logic [1:0] r,
                                          input logic [2:0] f);
      logic [17:0] row;
      logic [4:0] k;
      k = {d, r};
      case (k)
         5'd0:  row = {3'd5,3'd4,3'd3,3'd2,3'd1,3'd0};
         5'd1:  row = {3'd1,3'd0,3'd3,3'd2,3'd4,3'd5};
         5'd2:  row = {3'd0,3'd1,3'd3,3'd2,3'd5,3'd4};
         5'd3:  row = {3'd4,3'd5,3'd3,3'd2,3'd0,3'd1};
         5'd4:  row = {3'd5,3'd4,3'd2,3'd3,3'd0,3'd1};
         5'd5:  row = {3'd0,3'd1,3'd2,3'd3,3'd4,3'd5};
         5'd6:  row = {3'd1,3'd0,3'd2,3'd3,3'd5,3'd4};
         5'd7:  row = {3'd4,3'd5,3'd2,3'd3,3'd1,3'd0};
         5'd8:  row = {3'd5,3'd4,3'd1,3'd0,3'd2,3'd3};
         5'd9:  row = {3'd0,3'd1,3'd5,3'd4,3'd2,3'd3};
         5'd10: row = {3'd1,3'd0,3'd4,3'd5,3'd2,3'd3};
         5'd11: row = {3'd4,3'd5,3'd0,3'd1,3'd2,3'd3};
         5'd12: row = {3'd5,3'd4,3'd0,3'd1,3'd3,3'd2};
         5'd13: row = {3'd0,3'd1,3'd4,3'd5,3'd3,3'd2};
         5'd14: row = {3'd1,3'd0,3'd5,3'd4,3'd3,3'd2};
         5'd15: row = {3'd4,3'd5,3'd1,3'd0,3'd3,3'd2};
         5'd16: row = {3'd3,3'd2,3'd4,3'd5,3'd1,3'd0};
         5'd17: row = {3'd3,3'd2,3'd0,3'd1,3'd4,3'd5};
         5'd18: row = {3'd3,3'd2,3'd1,3'd0,3'd5,3'd4};
         5'd19: row = {3'd3,3'd2,3'd5,3'd4,3'd0,3'd1};
         5'd20: row = {3'd2,3'd3,3'd5,3'd4,3'd1,3'd0};
         5'd21: row = {3'd2,3'd3,3'd0,3'd1,3'd5,3'd4};
         5'd22: row = {3'd2,3'd3,3'd1,3'd0,3'd4,3'd5};
         5'd23: row = {3'd2,3'd3,3'd4,3'd5,3'd0,3'd1};
         default: row = '0;
      endcase
      return row[3*f +: 3];
   endfunction

   // orientation code for one face: four 2-bit codes, corner 0 at low bits
   function automatic logic [7:0] pk(input logic [1:0] a, input logic [1:0] b,
                                     input logic [1:0] c, input logic [1:0] e);
      return {e, c, b, a};
   endfunction

   function automatic logic [7:0] orient_row(input logic [2:0] d, input logic [1:0] r,
                                             input logic [2:0] f);
      logic [7:0] c0123, c1032, c2031, c0213, c1302, c2301, c3210, c3120;
      logic [7:0] row [6];
      logic [4:0] k;
      c0123 = pk(2'd0, 2'd1, 2'd2, 2'd3); c1032 = pk(2'd1, 2'd0, 2'd3, 2'd2);
      c2031 = pk(2'd2, 2'd0, 2'd3, 2'd1); c0213 = pk(2'd0, 2'd2, 2'd1, 2'd3);
      c1302 = pk(2'd1, 2'd3, 2'd0, 2'd2); c2301 = pk(2'd2, 2'd3, 2'd0, 2'd1);
      c3210 = pk(2'd3, 2'd2, 2'd1, 2'd0); c3120 = pk(2'd3, 2'd1, 2'd2, 2'd0);
      k = {d, r};
      row = '{c0123, c0123, c0123, c0123, c0123, c0123};
      case (k)
         5'd0:  row = '{c0123,c1032,c2031,c0213,c0213,c1302};
         5'd1:  row = '{c1032,c0123,c0123,c2301,c1302,c0213};
         5'd2:  row = '{c1032,c0123,c3210,c1032,c1302,c0213};
         5'd3:  row = '{c0123,c1032,c1302,c3120,c0213,c1302};
         5'd4:  row = '{c3210,c2301,c1302,c3120,c3120,c2031};
         5'd5:  row = '{c2301,c3210,c3210,c1032,c2031,c3120};
         5'd6:  row = '{c2301,c3210,c0123,c2301,c2031,c3120};
         5'd7:  row = '{c3210,c2301,c2031,c0213,c3120,c2031};
         5'd8:  row = '{c1302,c3120,c0123,c1032,c1032,c0123};
         5'd9:  row = '{c3210,c1032,c1032,c0123,c0123,c1032};
         5'd10: row = '{c0123,c2301,c1032,c0123,c0123,c1032};
         5'd11: row = '{c2031,c0213,c0123,c1032,c1032,c0123};
         5'd12: row = '{c2031,c0213,c3210,c2301,c2301,c3210};
         5'd13: row = '{c3210,c1032,c2301,c3210,c3210,c2301};
         5'd14: row = '{c0123,c2301,c0123,c3210,c3210,c2301};
         5'd15: row = '{c1302,c3120,c3210,c2301,c2301,c3210};
         5'd16: row = '{c2031,c3120,c3120,c2031,c2031,c0213};
         5'd17: row = '{c3120,c2031,c2031,c3120,c0123,c2301};
         5'd18: row = '{c3120,c2031,c2031,c3120,c3210,c1032};
         5'd19: row = '{c2031,c3120,c3120,c2031,c1302,c3120};
         5'd20: row = '{c1302,c0213,c0213,c1302,c2031,c0213};
         5'd21: row = '{c0213,c1302,c1302,c0213,c0123,c2301};
         5'd22: row = '{c0213,c1302,c1302,c0213,c3210,c1032};
         5'd23: row = '{c1302,c0213,c0213,c1302,c0213,c3120};
         default: row = '{c0123, c0123, c0123, c0123, c0123, c0123};
      endcase
      return (f < 3'd6) ? row[f] : c0123;
   endfunction

   // face corner used by vertex v, plain or flipped split; odd faces mirror
   function automatic logic [1:0] split_corner(input logic odd, input logic flip,
                                               input logic [2:0] v);
      logic [11:0] row;
      case ({flip, odd})
         2'b00: row = {2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};
         2'b01: row = {2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0};
         2'b10: row = {2'd2, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0};
         default: row = {2'd1, 2'd3, 2'd2, 2'd1, 2'd2, 2'd0};
      endcase
      return row[2*v +: 2];
   endfunction

endpackage

// ===== rtl/pvfm_vertex_gen.sv =====
// sequences the six vertices of one face and packs them
`timescale 1ns / 1ps
module pvfm_vertex_gen (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pvfm_pkg::req_type    face_req,
   input  logic [7:0]           tile,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pvfm_pkg::rsp_type    rsp_data
);

   logic                 active_ff, active_in;
   logic [2:0]           vtx_ff, vtx_in;
   logic                 flip_ff, flip_in;
   logic [7:0]           orient_ff, orient_in;
   pvfm_pkg::req_type    req_ff, req_in;
   logic [7:0]           tile_ff, tile_in;
   logic                 ovalid_ff, ovalid_in;
   pvfm_pkg::rsp_type    odata_ff, odata_in;

   logic [5:0] sum03, sum12;
   logic [1:0] j;
   logic [1:0] code;
   logic [4:0] aoj;
   logic [31:0] w0;
   logic [4:0] tu, tv;
   logic       advance;
   logic       out_free;

   assign out_free = !ovalid_ff || rsp_ready;
   assign advance = active_ff && out_free;
   assign busy = active_ff && !(advance && vtx_ff == 3'd5);

   // tile arrives in the cycle after start, from the registered memory read
   logic load_ff;

   always_comb begin
      sum03 = {1'b0, face_req.ao_corners[4:0]} + {1'b0, face_req.ao_corners[19:15]};
      sum12 = {1'b0, face_req.ao_corners[9:5]} + {1'b0, face_req.ao_corners[14:10]};
      j = pvfm_pkg::split_corner(req_ff.face[0], flip_ff, vtx_ff);
      code = orient_ff[2*j +: 2];
      aoj = req_ff.ao_corners[5*j +: 5];
      w0 = {29'd0, req_ff.face}
         + {26'd0, pvfm_pkg::corner_of(req_ff.face, j), 3'd0}
         + {20'd0, req_ff.pos_x, 7'd0}
         + {15'd0, req_ff.pos_y, 12'd0}
         + {10'd0, req_ff.pos_z, 17'd0}
         + {5'd0, aoj, 22'd0}
         + {({1'b0, req_ff.damage} + {4'd0, code[0]}), 27'd0}
         + {code[1], 31'd0};
      tu = {1'b0, tile_ff[3:0]} + {4'd0, code[0]};
      tv = {1'b0, tile_ff[7:4]} + {4'd0, code[1]};

      active_in = active_ff;
      vtx_in = vtx_ff;
      flip_in = flip_ff;
      orient_in = orient_ff;
      req_in = req_ff;
      tile_in = load_ff ? tile : tile_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      odata_in = odata_ff;
      if (advance) begin
         ovalid_in = 1'b1;
         odata_in.vertex_word0 = w0;
         odata_in.vertex_word1 = {tv, tu};
         odata_in.last_vertex = (vtx_ff == 3'd5);
         vtx_in = vtx_ff + 3'd1;
         if (vtx_ff == 3'd5) begin
            active_in = 1'b0;
         end
      end
      if (start) begin
         req_in = face_req;
         flip_in = sum03 > sum12;
         orient_in = pvfm_pkg::orient_row(face_req.direction, face_req.rotation,
                                          face_req.face);
         vtx_in = 3'd0;
      end
   end

   // start loads; via pend_ff it sets active_ff, and generation begins once the tile is in
   logic pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         load_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         load_ff <= start;
         pend_ff <= start;
         active_ff <= pend_ff ? 1'b1 : active_in;
      end
      vtx_ff <= vtx_in;
      flip_ff <= flip_in;
      orient_ff <= orient_in;
      req_ff <= req_in;
      tile_ff <= tile_in;
      odata_ff <= odata_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_data = odata_ff;

endmodule

// ===== rtl/packed_voxel_face_mesher_top.sv =====
// top level of the packed voxel face mesher
`timescale 1ns / 1ps
// packed voxel face mesher
// req channel: one transaction per command. cmd write stores tile_value into the
// tile table at (block_type, face); cmd emit produces six rsp transactions, the
// vertices of the face's two triangles, last_vertex set on the sixth.
// a write gives no response and leaves req_ready high. an emit with face or
// direction above five gives no response.
// an emit reads the tile table (synchronous ram, registered read); the face is
// then sequenced one vertex per cycle while rsp is not stalled, on the single
// output port. after accept the emit passes pend_ff, then active_ff, before its
// first vertex is registered in the output register.
// the next face is taken in the cycle the current sixth vertex is produced, and
// its tile read and load leave the output idle between faces. a stalled rsp holds
// the output register and the sequencer waits; req_ready drops while a face is
// in progress.
// reset clears control state only; tile table contents are undefined until
// written, and no clearing pass is run.
module packed_voxel_face_mesher_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pvfm_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pvfm_pkg::rsp_type    rsp_data
);

   logic [7:0] tile_mem [pvfm_pkg::TableDepth];
   logic [7:0] rd_ff;
   logic       rd_ok_ff;
   logic       busy;
   logic       pend_ff;
   logic       accept, start, wr_en;
   logic [2:0] slot;
   logic [pvfm_pkg::TableAw-1:0] wr_addr, rd_addr;

   // a started face is in load for one cycle before the sequencer owns it
   assign req_ready = !busy && !pend_ff;
   assign accept = req_valid && req_ready;
   assign start = accept && req_data.cmd == pvfm_pkg::CMD_EMIT
                  && req_data.face < 3'd6 && req_data.direction < 3'd6;
   assign wr_en = accept && req_data.cmd == pvfm_pkg::CMD_WRITE && req_data.face < 3'd6;
   assign slot = pvfm_pkg::slot_of(req_data.direction, req_data.rotation, req_data.face);
   assign wr_addr = pvfm_pkg::TableAw'({3'd0, req_data.block_type} * 11'd6)
                    + pvfm_pkg::TableAw'(req_data.face);
   assign rd_addr = pvfm_pkg::TableAw'({3'd0, req_data.block_type} * 11'd6)
                    + pvfm_pkg::TableAw'(slot);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tile_mem[wr_addr] <= req_data.tile_value;
      end
      rd_ff <= tile_mem[rd_addr];
      rd_ok_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= start;
      end
   end

   pvfm_vertex_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .face_req  (req_data),
      .tile      (rd_ok_ff ? rd_ff : 8'd0),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb_top.sv =====
// testbench for the packed voxel face mesher: random and directed faces against a predictor
`timescale 1ns / 1ps
module tb_top;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 20;

   typedef enum logic [2:0] {
      DIR_UP, DIR_DOWN, DIR_RIGHT, DIR_LEFT, DIR_FORWARD, DIR_BACKWARD
   } dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pvfm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pvfm_pkg::rsp_type rsp_data;

   packed_voxel_face_mesher_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // mesher tables, same layout as the block's behavior
   byte unsigned cube_corner [6][4] = '{
      '{0,1,2,5}, '{3,6,4,7}, '{2,5,4,7}, '{0,1,3,6}, '{0,2,3,4}, '{1,5,6,7}};
   byte unsigned tex_orient [6][4][6][4] = '{
      '{'{'{0,1,2,3},'{1,0,3,2},'{2,0,3,1},'{0,2,1,3},'{0,2,1,3},'{1,3,0,2}},
        '{'{1,0,3,2},'{0,1,2,3},'{0,1,2,3},'{2,3,0,1},'{1,3,0,2},'{0,2,1,3}},
        '{'{1,0,3,2},'{0,1,2,3},'{3,2,1,0},'{1,0,3,2},'{1,3,0,2},'{0,2,1,3}},
        '{'{0,1,2,3},'{1,0,3,2},'{1,3,0,2},'{3,1,2,0},'{0,2,1,3},'{1,3,0,2}}},
      '{'{'{3,2,1,0},'{2,3,0,1},'{1,3,0,2},'{3,1,2,0},'{3,1,2,0},'{2,0,3,1}},
        '{'{2,3,0,1},'{3,2,1,0},'{3,2,1,0},'{1,0,3,2},'{2,0,3,1},'{3,1,2,0}},
        '{'{2,3,0,1},'{3,2,1,0},'{0,1,2,3},'{2,3,0,1},'{2,0,3,1},'{3,1,2,0}},
        '{'{3,2,1,0},'{2,3,0,1},'{2,0,3,1},'{0,2,1,3},'{3,1,2,0},'{2,0,3,1}}},
      '{'{'{1,3,0,2},'{3,1,2,0},'{0,1,2,3},'{1,0,3,2},'{1,0,3,2},'{0,1,2,3}},
        '{'{3,2,1,0},'{1,0,3,2},'{1,0,3,2},'{0,1,2,3},'{0,1,2,3},'{1,0,3,2}},
        '{'{0,1,2,3},'{2,3,0,1},'{1,0,3,2},'{0,1,2,3},'{0,1,2,3},'{1,0,3,2}},
        '{'{2,0,3,1},'{0,2,1,3},'{0,1,2,3},'{1,0,3,2},'{1,0,3,2},'{0,1,2,3}}},
      '{'{'{2,0,3,1},'{0,2,1,3},'{3,2,1,0},'{2,3,0,1},'{2,3,0,1},'{3,2,1,0}},
        '{'{3,2,1,0},'{1,0,3,2},'{2,3,0,1},'{3,2,1,0},'{3,2,1,0},'{2,3,0,1}},
        '{'{0,1,2,3},'{2,3,0,1},'{0,1,2,3},'{3,2,1,0},'{3,2,1,0},'{2,3,0,1}},
        '{'{1,3,0,2},'{3,1,2,0},'{3,2,1,0},'{2,3,0,1},'{2,3,0,1},'{3,2,1,0}}},
      '{'{'{2,0,3,1},'{3,1,2,0},'{3,1,2,0},'{2,0,3,1},'{2,0,3,1},'{0,2,1,3}},
        '{'{3,1,2,0},'{2,0,3,1},'{2,0,3,1},'{3,1,2,0},'{0,1,2,3},'{2,3,0,1}},
        '{'{3,1,2,0},'{2,0,3,1},'{2,0,3,1},'{3,1,2,0},'{3,2,1,0},'{1,0,3,2}},
        '{'{2,0,3,1},'{3,1,2,0},'{3,1,2,0},'{2,0,3,1},'{1,3,0,2},'{3,1,2,0}}},
      '{'{'{1,3,0,2},'{0,2,1,3},'{0,2,1,3},'{1,3,0,2},'{2,0,3,1},'{0,2,1,3}},
        '{'{0,2,1,3},'{1,3,0,2},'{1,3,0,2},'{0,2,1,3},'{0,1,2,3},'{2,3,0,1}},
        '{'{0,2,1,3},'{1,3,0,2},'{1,3,0,2},'{0,2,1,3},'{3,2,1,0},'{1,0,3,2}},
        '{'{1,3,0,2},'{0,2,1,3},'{0,2,1,3},'{1,3,0,2},'{0,2,1,3},'{3,1,2,0}}}};
   byte unsigned tex_slot [6][4][6] = '{
      '{'{0,1,2,3,4,5},'{5,4,2,3,0,1},'{4,5,2,3,1,0},'{1,0,2,3,5,4}},
      '{'{1,0,3,2,4,5},'{5,4,3,2,1,0},'{4,5,3,2,0,1},'{0,1,3,2,5,4}},
      '{'{3,2,0,1,4,5},'{3,2,4,5,1,0},'{3,2,5,4,0,1},'{3,2,1,0,5,4}},
      '{'{2,3,1,0,4,5},'{2,3,5,4,1,0},'{2,3,4,5,0,1},'{2,3,0,1,5,4}},
      '{'{0,1,5,4,2,3},'{5,4,1,0,2,3},'{4,5,0,1,2,3},'{1,0,4,5,2,3}},
      '{'{0,1,4,5,3,2},'{4,5,1,0,3,2},'{5,4,0,1,3,2},'{1,0,5,4,3,2}}};
   byte unsigned tri_plain [2][6] = '{'{0,3,2,0,1,3}, '{0,3,1,0,2,3}};
   byte unsigned tri_flip [2][6] = '{'{0,1,2,1,3,2}, '{0,2,1,2,3,1}};

   logic [7:0] tile_shadow [pvfm_pkg::TableDepth];
   bit tile_written [pvfm_pkg::TableDepth];
   pvfm_pkg::req_type pending_reqs [$];
   pvfm_pkg::rsp_type expected_vertices [$];
   int errors = 0;
   int faces_sent = 0;
   int vertices_seen = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   // predicted vertices of one accepted transaction
   task automatic mesh_face(input pvfm_pkg::req_type r);
      int ao [4];
      int flip, j, code, ub, vb, tile;
      logic [31:0] w0;
      pvfm_pkg::rsp_type v;
      if (r.cmd == pvfm_pkg::CMD_WRITE) begin
         if (r.face < 6) tile_shadow[r.block_type * 6 + r.face] = r.tile_value;
         return;
      end
      if (r.face >= 6 || r.direction >= 6) return;
      for (int k = 0; k < 4; k++) ao[k] = (r.ao_corners >> (5 * k)) & 31;
      flip = (ao[0] + ao[3] > ao[1] + ao[2]);
      tile = tile_shadow[r.block_type * 6 + tex_slot[r.direction][r.rotation][r.face]];
      for (int n = 0; n < 6; n++) begin
         j = flip ? tri_flip[r.face % 2][n] : tri_plain[r.face % 2][n];
         code = tex_orient[r.direction][r.rotation][r.face][j];
         ub = code & 1;
         vb = (code >> 1) & 1;
         w0 = 32'(r.face) + (32'(cube_corner[r.face][j]) << 3) + (32'(r.pos_x) << 7)
            + (32'(r.pos_y) << 12) + (32'(r.pos_z) << 17) + (32'(ao[j]) << 22)
            + ((32'(r.damage) + 32'(ub)) << 27) + (32'(vb) << 31);
         v.vertex_word0 = w0;
         v.vertex_word1 = 10'((tile % 16 + ub) + ((tile / 16 + vb) << 5));
         v.last_vertex = (n == 5);
         expected_vertices.push_back(v);
      end
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // random emit whose tile entry has already been written
   function automatic pvfm_pkg::req_type random_emit();
      pvfm_pkg::req_type r;
      r = pvfm_pkg::req_type'({$urandom, $urandom});
      r.cmd = pvfm_pkg::CMD_EMIT;
      do begin
         r.face = 3'($urandom_range(0, 5));
         r.direction = 3'($urandom_range(0, 5));
         r.rotation = 2'($urandom_range(0, 3));
         r.block_type = 8'($urandom_range(0, 255));
      end while (!tile_written[r.block_type * 6
                               + tex_slot[r.direction][r.rotation][r.face]]);
      r.damage = 4'($urandom_range(0, 14));
      return r;
   endfunction

   function automatic pvfm_pkg::req_type make_write(input int bt, input int slot,
                                                    input int val);
      pvfm_pkg::req_type r;
      r = pvfm_pkg::req_type'({$urandom, $urandom});
      r.cmd = pvfm_pkg::CMD_WRITE;
      r.block_type = 8'(bt);
      r.face = 3'(slot);
      r.tile_value = 8'(val);
      if (slot < 6) tile_written[bt * 6 + slot] = 1'b1;
      return r;
   endfunction

   // driver
   int drv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold the transaction
      end else begin
         if (req_valid) mesh_face(req_data);
         if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            drv_gap <= gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   int rcv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
               $error("unexpected vertex transaction %h", rsp_data);
               errors++;
            end else begin
               pvfm_pkg::rsp_type e;
               e = expected_vertices.pop_front();
               if (e.vertex_word0 !== rsp_data.vertex_word0) begin
                  $error("vertex_word0 expected %h actual %h", e.vertex_word0,
                         rsp_data.vertex_word0);
                  errors++;
               end
               if (e.vertex_word1 !== rsp_data.vertex_word1) begin
                  $error("vertex_word1 expected %h actual %h", e.vertex_word1,
                         rsp_data.vertex_word1);
                  errors++;
               end
               if (e.last_vertex !== rsp_data.last_vertex) begin
                  $error("last_vertex expected %b actual %b", e.last_vertex,
                         rsp_data.last_vertex);
                  errors++;
               end
            end
         end
         if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rcv_gap <= gap_len();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired with %0d vertices outstanding",
                  expected_vertices.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      pvfm_pkg::req_type r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: fill two rows, extremes of most fields, ignored commands
      for (int s = 0; s < 6; s++) pending_reqs.push_back(make_write(0, s, s * 51));
      for (int s = 0; s < 6; s++) pending_reqs.push_back(make_write(255, s, 255 - s));
      pending_reqs.push_back(make_write(7, 6, 8'h5a));   // slot out of range
      pending_reqs.push_back(make_write(7, 7, 8'ha5));
      r = '1; r.cmd = pvfm_pkg::CMD_EMIT; r.face = 3'd5; r.direction = DIR_BACKWARD;
      r.block_type = 8'd255;
      r.damage = 4'd14;
      pending_reqs.push_back(r);
      r = '0; r.cmd = pvfm_pkg::CMD_EMIT;
      pending_reqs.push_back(r);
      r.ao_corners = {5'd31, 5'd0, 5'd0, 5'd31};        // flipped split
      r.face = 3'd2; r.direction = DIR_RIGHT;
      pending_reqs.push_back(r);
      r.ao_corners = {5'd31, 5'd31, 5'd31, 5'd31};      // plain split, equal sums
      pending_reqs.push_back(r);
      r.face = 3'd6;                                    // face out of range
      pending_reqs.push_back(r);
      r.face = 3'd1; r.direction = 3'd7;                // direction out of range
      pending_reqs.push_back(r);

      // random: mostly emits, writes interleaved to grow the table
      for (int n = 0; n < 500; n++) begin
         if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(make_write($urandom_range(0, 255), $urandom_range(0, 7),
                                              $urandom_range(0, 255)));
         else if ($urandom_range(0, 19) == 0) begin
            r = random_emit();
            if ($urandom_range(0, 1)) r.face = 3'($urandom_range(6, 7));
            else r.direction = 3'($urandom_range(6, 7));
            pending_reqs.push_back(r);
         end else begin
            pending_reqs.push_back(random_emit());
            faces_sent++;
         end
      end

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_vertices.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d random faces plus directed cases, %0d vertices checked",
               faces_sent, vertices_seen);
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
